// ===== rtl/xcpd_pkg.sv =====
// Package with the shared types and constants of the XOR checksum packet deframer.
`default_nettype none

package xcpd_pkg;

	localparam int BUFFER_DEPTH_DEF = 256;
	localparam int PAYLOAD_LIMIT = 200;
	localparam logic [7:0] MAX_LEN_RESET = 8'(PAYLOAD_LIMIT + 1);

	localparam logic [7:0] SYNC_CHAR = 8'h24;
	localparam logic [7:0] CR_CHAR = 8'h0D;
	localparam logic [7:0] LF_CHAR = 8'h0A;

	typedef enum logic [2:0] {
		PH_SYNC1,
		PH_SYNC2,
		PH_TYPE,
		PH_LEN,
		PH_BODY,
		PH_CHK,
		PH_CR,
		PH_LF
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_OK   = 3'd1,
		EV_LONG = 3'd2,
		EV_CHK  = 3'd3,
		EV_CR   = 3'd4,
		EV_LF   = 3'd5
	} event_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
		logic [7:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [7:0] frame_type;
		logic [7:0] frame_length;
		logic [7:0] computed_checksum;
		logic [7:0] read_data;
	} out_item_t;

	typedef struct packed {
		event_t     ev;
		logic [7:0] frame_type;
		logic [7:0] frame_length;
		logic [7:0] computed_checksum;
	} parse_res_t;

endpackage

`default_nettype wire

// ===== rtl/xcpd_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module xcpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = xcpd_pkg::BUFFER_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/xcpd_parser.sv =====
// Frame parser state machine with header, length, checksum and trailer checks.
`default_nettype none

module xcpd_parser #(
	parameter int BUFFER_DEPTH = xcpd_pkg::BUFFER_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            step,
	input  wire logic [7:0]                      rx_byte,
	input  wire logic [7:0]                      max_len,
	output xcpd_pkg::parse_res_t                 res,
	output logic                                 wr_en,
	output logic      [$clog2(BUFFER_DEPTH)-1:0] wr_addr
);

	localparam int AW = $clog2(BUFFER_DEPTH);

	xcpd_pkg::phase_t phase_q;
	xcpd_pkg::phase_t phase_d;
	logic [7:0]       type_q;
	logic [7:0]       len_q;
	logic [7:0]       prog_q;
	logic [7:0]       chk_q;
	logic [7:0]       prog_inc;
	logic             in_range;
	xcpd_pkg::event_t ev;

	assign prog_inc = prog_q + 8'd1;
	assign in_range = {1'b0, prog_q} < 9'(BUFFER_DEPTH);

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			xcpd_pkg::PH_SYNC1, xcpd_pkg::PH_SYNC2: begin
				if (rx_byte == xcpd_pkg::SYNC_CHAR) begin
					phase_d = (phase_q == xcpd_pkg::PH_SYNC1) ? xcpd_pkg::PH_SYNC2
						: xcpd_pkg::PH_TYPE;
				end else begin
					phase_d = xcpd_pkg::PH_SYNC1;
				end
			end
			xcpd_pkg::PH_TYPE: begin
				phase_d = xcpd_pkg::PH_LEN;
			end
			xcpd_pkg::PH_LEN: begin
				if (rx_byte == 8'd0) begin
					phase_d = xcpd_pkg::PH_CHK;
				end else if (rx_byte <= max_len) begin
					phase_d = xcpd_pkg::PH_BODY;
				end else begin
					phase_d = xcpd_pkg::PH_SYNC1;
				end
			end
			xcpd_pkg::PH_BODY: begin
				if (prog_inc == len_q) begin
					phase_d = xcpd_pkg::PH_CHK;
				end
			end
			xcpd_pkg::PH_CHK: begin
				phase_d = (chk_q == rx_byte) ? xcpd_pkg::PH_CR : xcpd_pkg::PH_SYNC1;
			end
			xcpd_pkg::PH_CR: begin
				phase_d = (rx_byte == xcpd_pkg::CR_CHAR) ? xcpd_pkg::PH_LF
					: xcpd_pkg::PH_SYNC1;
			end
			xcpd_pkg::PH_LF: begin
				phase_d = xcpd_pkg::PH_SYNC1;
			end
			default: begin
				phase_d = xcpd_pkg::PH_SYNC1;
			end
		endcase
	end

	always_comb begin
		ev = xcpd_pkg::EV_NONE;
		wr_en = 1'b0;
		if (step) begin
			unique case (phase_q)
				xcpd_pkg::PH_LEN: begin
					if (rx_byte != 8'd0 && rx_byte > max_len) begin
						ev = xcpd_pkg::EV_LONG;
					end
				end
				xcpd_pkg::PH_BODY: begin
					wr_en = in_range;
				end
				xcpd_pkg::PH_CHK: begin
					if (chk_q != rx_byte) begin
						ev = xcpd_pkg::EV_CHK;
					end
				end
				xcpd_pkg::PH_CR: begin
					if (rx_byte != xcpd_pkg::CR_CHAR) begin
						ev = xcpd_pkg::EV_CR;
					end
				end
				xcpd_pkg::PH_LF: begin
					ev = (rx_byte == xcpd_pkg::LF_CHAR) ? xcpd_pkg::EV_OK : xcpd_pkg::EV_LF;
				end
				default: begin
					ev = xcpd_pkg::EV_NONE;
				end
			endcase
		end
	end

	assign wr_addr = prog_q[AW-1:0];

	always_comb begin
		res.ev = ev;
		res.frame_type = 8'd0;
		res.frame_length = 8'd0;
		res.computed_checksum = 8'd0;
		if (ev != xcpd_pkg::EV_NONE) begin
			res.frame_type = type_q;
			res.frame_length = (phase_q == xcpd_pkg::PH_LEN) ? rx_byte : len_q;
			res.computed_checksum = (phase_q == xcpd_pkg::PH_LEN) ? 8'd0 : chk_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= xcpd_pkg::PH_SYNC1;
			type_q <= 8'd0;
			len_q <= 8'd0;
			prog_q <= 8'd0;
			chk_q <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			if (phase_q == xcpd_pkg::PH_TYPE) begin
				type_q <= rx_byte;
			end
			if (phase_q == xcpd_pkg::PH_LEN) begin
				len_q <= rx_byte;
				prog_q <= 8'd0;
				chk_q <= 8'd0;
			end
			if (phase_q == xcpd_pkg::PH_BODY) begin
				prog_q <= prog_inc;
				chk_q <= chk_q ^ rx_byte;
			end
		end
	end

	a_event_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && ev != xcpd_pkg::EV_NONE |=> phase_q == xcpd_pkg::PH_SYNC1)
		else $error("parser did not restart after a terminal event");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(phase_q) && $stable(prog_q) && $stable(chk_q))
		else $error("parser state changed without a received byte");

	a_body_counts: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == xcpd_pkg::PH_BODY |=> prog_q == $past(prog_q) + 8'd1)
		else $error("payload position did not advance on a payload byte");

endmodule

`default_nettype wire

// ===== rtl/xor_checksum_packet_deframer.sv =====
// Top level of the XOR checksum packet deframer with payload buffer and output register.
// An accepted transfer goes through the middle stage register, then the output register.
// Throughput: one item per cycle unless stalled; parser and buffer port each take one step.
// A result waiting on out_data does not block input while the middle stage is free.
// Reset clears the parser, the pipeline valids and sets max_payload_length to 201.
// The payload buffer is not cleared by reset; its entries are undefined until written.
`default_nettype none

module xor_checksum_packet_deframer #(
	parameter int BUFFER_DEPTH = xcpd_pkg::BUFFER_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [7:0]          cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire xcpd_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output xcpd_pkg::out_item_t      out_data
);

	localparam int AW = $clog2(BUFFER_DEPTH);

	logic [7:0]           max_payload_length_q;
	logic                 in_accept;
	logic                 step;
	logic                 s1_adv;
	logic                 rd_ok;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [7:0]           rd_data;
	xcpd_pkg::parse_res_t res;
	logic                 s1_valid;
	logic                 s1_kind;
	logic                 s1_rd_ok;
	xcpd_pkg::parse_res_t s1_res;
	logic                 out_valid_q;
	xcpd_pkg::out_item_t  out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_length_q <= xcpd_pkg::MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_payload_length_q <= cfg_wdata;
		end
	end

	assign s1_adv = !out_valid_q || !out_stall;
	assign in_stall = s1_valid && !s1_adv;
	assign in_accept = in_valid && !in_stall;
	assign step = in_accept && !in_data.kind;
	assign rd_ok = {1'b0, in_data.read_index} < 9'(BUFFER_DEPTH);

	xcpd_parser #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (in_data.rx_byte),
		.max_len (max_payload_length_q),
		.res     (res),
		.wr_en   (wr_en),
		.wr_addr (wr_addr)
	);

	xcpd_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_DEPTH)
	) u_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (in_data.rx_byte),
		.rd_en   (in_accept && in_data.kind),
		.rd_addr (in_data.read_index[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_accept) begin
			s1_valid <= 1'b1;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			s1_kind <= in_data.kind;
			s1_rd_ok <= rd_ok;
			s1_res <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid) begin
			out_data_q.event_res <= s1_res.ev;
			out_data_q.frame_type <= s1_res.frame_type;
			out_data_q.frame_length <= s1_res.frame_length;
			out_data_q.computed_checksum <= s1_res.computed_checksum;
			out_data_q.read_data <= (s1_kind && s1_rd_ok) ? rd_data : 8'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	a_read_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && in_data.kind |=> s1_valid && s1_res.ev == xcpd_pkg::EV_NONE)
		else $error("read item produced a parser event");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !s1_adv |=> s1_valid && $stable(s1_kind) && $stable(s1_res))
		else $error("middle stage lost or changed a waiting result");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid && out_valid_q && out_stall)
		else $error("input stalled while a stage was free");

	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> step && !in_data.kind)
		else $error("payload buffer written without a received byte");

endmodule

`default_nettype wire
